/* rtl/pup_pkg.sv */
package pup_pkg;

  localparam int unsigned CFG_W          = 13;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned MAX_SCREEN_DEF = 4096;
  localparam int unsigned POS_W          = 16;
  localparam int unsigned VEL_W          = 11;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned KIND_W         = 3;
  localparam int unsigned IDX_W          = 24;
  localparam int unsigned IN_DATA_W      = 72;
  localparam int unsigned OUT_DATA_W     = 88;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;

  typedef enum logic [KIND_W-1:0] {
    KIND_BALLISTIC = 3'd0,
    KIND_TRAIL     = 3'd1,
    KIND_RADIAL    = 3'd2,
    KIND_SHRINK    = 3'd3,
    KIND_WATERFALL = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  // moved particle, after the first stage
  typedef struct packed {
    kind_e             kind;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [VEL_W-1:0]  vx;
    logic [VEL_W-1:0]  vy;
    logic [BYTE_W-1:0] heat;
    logic [BYTE_W-1:0] life;
    logic              was_dead;
  } move_t;

  // result fields except the pixel index
  typedef struct packed {
    logic [POS_W-1:0]  new_pos_x;
    logic [POS_W-1:0]  new_pos_y;
    logic [VEL_W-1:0]  new_vel_y;
    logic [BYTE_W-1:0] new_heat;
    logic [BYTE_W-1:0] new_life_count;
    logic              now_dead;
    logic              plot;
  } res_t;

endpackage

/* rtl/pup_move.sv */
module pup_move import pup_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [POS_W-1:0]  pos_x_i,
  input  logic [POS_W-1:0]  pos_y_i,
  input  logic [VEL_W-1:0]  vel_x_i,
  input  logic [VEL_W-1:0]  vel_y_i,
  input  logic [BYTE_W-1:0] heat_i,
  input  logic [BYTE_W-1:0] life_i,
  input  logic              is_dead_i,
  output logic              valid_o,
  input  logic              ready_i,
  output move_t             move_o
);

  logic        valid_q;
  move_t       move_d, move_q;
  kind_e       kind;
  logic [POS_W:0] sum_x, sum_y;

  function automatic logic [POS_W-1:0] sat16(input logic [POS_W:0] s);
    logic [POS_W-1:0] r;
    r = s[POS_W-1:0];
    if (s[POS_W] != s[POS_W-1]) begin
      r = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    return r;
  endfunction

  always_comb begin
    kind = (kind_i > KIND_WATERFALL) ? KIND_BALLISTIC : kind_e'(kind_i);
    sum_x = {pos_x_i[POS_W-1], pos_x_i}
          + {{(POS_W-VEL_W+1){vel_x_i[VEL_W-1]}}, vel_x_i};
    sum_y = {pos_y_i[POS_W-1], pos_y_i}
          + {{(POS_W-VEL_W+1){vel_y_i[VEL_W-1]}}, vel_y_i};
    move_d.kind     = kind;
    move_d.vx       = vel_x_i;
    move_d.vy       = vel_y_i;
    move_d.heat     = heat_i;
    move_d.was_dead = is_dead_i;
    if (is_dead_i) begin
      move_d.x    = pos_x_i;
      move_d.y    = pos_y_i;
      move_d.life = life_i;
    end else begin
      move_d.x    = sat16(sum_x);
      move_d.y    = sat16(sum_y);
      move_d.life = ((kind == KIND_SHRINK || kind == KIND_WATERFALL) && life_i != '0)
                  ? life_i - BYTE_W'(1) : life_i;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign move_o  = move_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      move_q <= move_d;
    end
  end

endmodule

/* rtl/pup_judge.sv */
module pup_judge import pup_pkg::*; #(
  parameter int unsigned DimW = 13
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [DimW-1:0] width_i,
  input  logic [DimW-1:0] height_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  move_t           move_i,
  output logic            valid_o,
  input  logic            ready_i,
  output res_t            res_o,
  output logic [DimW-1:0] px_o,
  output logic [DimW-1:0] py_o
);

  localparam int unsigned CW = POS_W + 2;

  logic                 valid_q;
  res_t                 res_d, res_q;
  logic [DimW-1:0]      px_d, px_q, py_d, py_q;
  logic signed [CW-1:0] xe, ye, xl, wm3, hm3;
  logic signed [VEL_W-1:0] vx, vy;
  logic side, look, rtop, common, life_zero, dead, gravity, plot;

  always_comb begin
    xe  = signed'({{2{move_i.x[POS_W-1]}}, move_i.x});
    ye  = signed'({{2{move_i.y[POS_W-1]}}, move_i.y});
    vx  = signed'(move_i.vx);
    vy  = signed'(move_i.vy);
    xl  = xe + signed'({{(CW-VEL_W){move_i.vx[VEL_W-1]}}, move_i.vx});
    wm3 = signed'({{(CW-DimW){1'b0}}, width_i}) - CW'(3);
    hm3 = signed'({{(CW-DimW){1'b0}}, height_i}) - CW'(3);

    side = (xe <= CW'(1) && vx <= VEL_W'(0)) || (xe >= wm3 && vx >= VEL_W'(0));
    look = (ye <= CW'(1))
        && ((vx > VEL_W'(0) && xl >= wm3) || (vx < VEL_W'(0) && xl <= CW'(1)));
    rtop = (ye <= CW'(1)) && (vy <= VEL_W'(0));
    common    = (move_i.heat == '0) || (ye >= hm3);
    life_zero = (move_i.life == '0);

    gravity = 1'b0;
    case (move_i.kind)
      KIND_BALLISTIC: begin
        dead    = common || side || look;
        gravity = 1'b1;
      end
      KIND_TRAIL: begin
        dead    = common || look || (vy > VEL_W'(0));
        gravity = 1'b1;
      end
      KIND_RADIAL: dead = common || side || rtop;
      KIND_SHRINK: dead = common || life_zero || side || rtop;
      KIND_WATERFALL: begin
        dead    = common || side || (life_zero && look);
        gravity = life_zero;
      end
      default: begin
        dead    = common || side || look;
        gravity = 1'b1;
      end
    endcase
    dead = dead || move_i.was_dead;
    plot = !dead && (ye > CW'(1)) && (xe > CW'(1)) && (xe < wm3);

    res_d.new_pos_x      = move_i.x;
    res_d.new_pos_y      = move_i.y;
    res_d.new_life_count = move_i.life;
    res_d.now_dead       = dead;
    res_d.plot           = plot;
    res_d.new_vel_y      = move_i.vy;
    res_d.new_heat       = move_i.heat;
    if (!dead) begin
      res_d.new_heat = move_i.heat - BYTE_W'(1);
      if (gravity && move_i.vy != {1'b0, {(VEL_W-1){1'b1}}}) begin
        res_d.new_vel_y = move_i.vy + VEL_W'(1);
      end
    end
    px_d = plot ? move_i.x[DimW-1:0] : '0;
    py_d = plot ? move_i.y[DimW-1:0] : '0;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;
  assign px_o    = px_q;
  assign py_o    = py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
      px_q  <= px_d;
      py_q  <= py_d;
    end
  end

endmodule

/* rtl/pup_index.sv */
module pup_index import pup_pkg::*; #(
  parameter int unsigned DimW = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DimW-1:0]  width_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  res_t             res_i,
  input  logic [DimW-1:0]  px_i,
  input  logic [DimW-1:0]  py_i,
  output logic             valid_o,
  input  logic             ready_i,
  output res_t             res_o,
  output logic [IDX_W-1:0] index_o
);

  localparam int unsigned PW = 2 * DimW;

  // multiply stage
  logic            mul_valid_q, mul_ready;
  res_t            mul_res_q;
  logic [PW-1:0]   prod_q;
  logic [DimW-1:0] mul_px_q;
  // add stage, the output register
  logic             out_valid_q;
  res_t             out_res_q;
  logic [IDX_W-1:0] index_d, index_q;
  logic [PW:0]      sum;

  assign mul_ready = !out_valid_q || ready_i;
  assign ready_o   = !mul_valid_q || mul_ready;

  always_comb begin
    sum     = {1'b0, prod_q} + {{(PW+1-DimW){1'b0}}, mul_px_q};
    index_d = IDX_W'(sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        mul_valid_q <= valid_i;
      end
      if (mul_ready) begin
        out_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q    <= py_i * width_i;
      mul_px_q  <= px_i;
      mul_res_q <= res_i;
    end
    if (mul_ready && mul_valid_q) begin
      index_q   <= index_d;
      out_res_q <= mul_res_q;
    end
  end

  assign valid_o = out_valid_q;
  assign res_o   = out_res_q;
  assign index_o = index_q;

endmodule

/* rtl/particle_update_and_plot.sv */
// Particle frame update and splat locator.
// Input stream s_axis: one particle record per item, kind on tuser, the rest
// on tdata. Output stream m_axis: one result item per input item, in order.
// Config channel cfg_*: index 0 writes the screen width, index 1 the screen
// height (13 bits each, clamped to 8..MaxScreen). cfg_ready_o is always high;
// write only while no item is in flight.
// Pipeline: four register stages - move/saturate, death and plot rules,
// y*width multiply, index add into the output register. An accepted item
// passes through them in that order; throughput is one item per cycle
// while m_axis_tready stays high.
// Reset clears all stage valid bits and loads width 640 and height 480.
// When the receiver holds m_axis_tready low, the output item holds and the
// stages behind it keep filling until each holds an item; s_axis_tready then
// drops. Nothing is lost or repeated across a stall.
module particle_update_and_plot import pup_pkg::*; #(
  parameter int unsigned MaxScreen = MAX_SCREEN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pos_x[15:0] pos_y[31:16] vel_x[42:32] vel_y[53:43] heat[61:54]
  // life_count[69:62] is_dead[70], bit 71 zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind[2:0]
  input  logic [KIND_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // new_pos_x[15:0] new_pos_y[31:16] new_vel_y[42:32] new_heat[50:43]
  // new_life_count[58:51] now_dead[59] plot[60] pixel_index[84:61], 87:85 zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned DimW = $clog2(MaxScreen + 1);

  logic [CFG_W-1:0] width_q, height_q;
  logic [DimW-1:0]  width_cl, height_cl;

  logic             mv_valid, mv_ready;
  move_t            mv;
  logic             jd_valid, jd_ready;
  res_t             jd_res;
  logic [DimW-1:0]  jd_px, jd_py;
  res_t             out_res;
  logic [IDX_W-1:0] out_index;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic [DimW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DimW-1:0] r;
    if (v < CFG_W'(8)) begin
      r = DimW'(8);
    end else if (v > CFG_W'(MaxScreen)) begin
      r = DimW'(MaxScreen);
    end else begin
      r = v[DimW-1:0];
    end
    return r;
  endfunction

  assign width_cl  = clamp_dim(width_q);
  assign height_cl = clamp_dim(height_q);

  pup_move u_move (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .kind_i    (s_axis_tuser),
    .pos_x_i   (s_axis_tdata[15:0]),
    .pos_y_i   (s_axis_tdata[31:16]),
    .vel_x_i   (s_axis_tdata[42:32]),
    .vel_y_i   (s_axis_tdata[53:43]),
    .heat_i    (s_axis_tdata[61:54]),
    .life_i    (s_axis_tdata[69:62]),
    .is_dead_i (s_axis_tdata[70]),
    .valid_o   (mv_valid),
    .ready_i   (mv_ready),
    .move_o    (mv)
  );

  pup_judge #(.DimW(DimW)) u_judge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .width_i  (width_cl),
    .height_i (height_cl),
    .valid_i  (mv_valid),
    .ready_o  (mv_ready),
    .move_i   (mv),
    .valid_o  (jd_valid),
    .ready_i  (jd_ready),
    .res_o    (jd_res),
    .px_o     (jd_px),
    .py_o     (jd_py)
  );

  pup_index #(.DimW(DimW)) u_index (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .width_i (width_cl),
    .valid_i (jd_valid),
    .ready_o (jd_ready),
    .res_i   (jd_res),
    .px_i    (jd_px),
    .py_i    (jd_py),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res),
    .index_o (out_index)
  );

  assign m_axis_tdata = {3'b000, out_index, out_res.plot, out_res.now_dead,
                         out_res.new_life_count, out_res.new_heat,
                         out_res.new_vel_y, out_res.new_pos_y, out_res.new_pos_x};

  a_plot_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_res.plot |-> !out_res.now_dead)
    else $error("plot on a dead particle");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !out_res.plot |-> out_index == '0)
    else $error("nonzero pixel index without plot");

  a_dim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    width_cl >= DimW'(8) && width_cl <= DimW'(MaxScreen)
    && height_cl >= DimW'(8) && height_cl <= DimW'(MaxScreen))
    else $error("clamped screen size out of range");

  a_judge_plot_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jd_valid && !jd_res.plot |-> jd_px == '0 && jd_py == '0)
    else $error("splat coordinates set without plot");

endmodule

/* tb/particle_checker.sv */
`timescale 1ns / 100ps

module particle_checker import pup_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic [KIND_W-1:0]     in_kind_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [OUT_DATA_W-1:0] out_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  // tdata layout of an input item, lowest field last
  typedef struct packed {
    logic                    zero;
    logic                    is_dead;
    logic [BYTE_W-1:0]       life;
    logic [BYTE_W-1:0]       heat;
    logic signed [VEL_W-1:0] vy;
    logic signed [VEL_W-1:0] vx;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] px;
  } particle_t;

  // tdata layout of a result item
  typedef struct packed {
    logic [2:0]        zero;
    logic [IDX_W-1:0]  pixel_index;
    logic              plot;
    logic              now_dead;
    logic [BYTE_W-1:0] life;
    logic [BYTE_W-1:0] heat;
    logic [VEL_W-1:0]  vy;
    logic [POS_W-1:0]  py;
    logic [POS_W-1:0]  px;
  } particle_out_t;

  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;
  particle_out_t    expected_results[$];
  particle_out_t    want;
  particle_out_t    got;
  int               fail_count;

  assign fail_count_o = fail_count;

  function automatic int clamp_dim(logic [CFG_W-1:0] v);
    if (v < 8) return 8;
    if (v > MAX_SCREEN_DEF) return MAX_SCREEN_DEF;
    return int'(v);
  endfunction

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic particle_out_t advance_particle(logic [KIND_W-1:0] kind_raw,
                                                    particle_t p);
    kind_e             kind;
    int                w, h, x, y, vx, vy, nvy;
    logic [BYTE_W-1:0] nlife, nheat;
    logic              dead, plot, grav, side, look, rtop;
    logic [31:0]       idx;
    particle_out_t     r;
    w = clamp_dim(width_q);
    h = clamp_dim(height_q);
    kind = (kind_raw > KIND_WATERFALL) ? KIND_BALLISTIC : kind_e'(kind_raw);
    x = p.px;
    y = p.py;
    vx = p.vx;
    vy = p.vy;
    nvy = vy;
    nlife = p.life;
    nheat = p.heat;
    dead = 1'b1;
    plot = 1'b0;
    grav = 1'b0;
    idx = '0;
    if (!p.is_dead) begin
      x = sat16(x + vx);
      y = sat16(y + vy);
      if (kind >= KIND_SHRINK && nlife > 0) nlife = nlife - 1'b1;
      side = (x <= 1 && vx <= 0) || (x >= w - 3 && vx >= 0);
      look = (y <= 1) && ((vx > 0 && x + vx >= w - 3) || (vx < 0 && x + vx <= 1));
      rtop = (y <= 1 && vy <= 0);
      dead = (p.heat == 0) || (y >= h - 3);
      case (kind)
        KIND_BALLISTIC: begin
          dead = dead || side || look;
          grav = 1'b1;
        end
        KIND_TRAIL: begin
          dead = dead || look || (vy > 0);
          grav = 1'b1;
        end
        KIND_RADIAL: dead = dead || side || rtop;
        KIND_SHRINK: dead = dead || (nlife == 0) || side || rtop;
        default: begin
          dead = dead || side || (nlife == 0 && look);
          grav = (nlife == 0);
        end
      endcase
      if (!dead) begin
        if (grav && nvy < 1023) nvy = nvy + 1;
        nheat = p.heat - 1'b1;
        if (y > 1 && x > 1 && x < w - 3) begin
          plot = 1'b1;
          idx = y * w + x;
        end
      end
    end
    r = '0;
    r.px = x[POS_W-1:0];
    r.py = y[POS_W-1:0];
    r.vy = nvy[VEL_W-1:0];
    r.heat = nheat;
    r.life = nlife;
    r.now_dead = dead;
    r.plot = plot;
    r.pixel_index = idx[IDX_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_WIDTH:  width_q <= cfg_data_i;
          REG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        expected_results.push_back(advance_particle(in_kind_i, particle_t'(in_data_i)));
      if (out_valid_i && out_ready_i) begin
        got = particle_out_t'(out_data_i);
        if (expected_results.size() == 0) begin
          $error("result item with none expected: 0x%0h", out_data_i);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("new_pos_x", want.px, got.px);
          check_field("new_pos_y", want.py, got.py);
          check_field("new_vel_y", want.vy, got.vy);
          check_field("new_heat", want.heat, got.heat);
          check_field("new_life_count", want.life, got.life);
          check_field("now_dead", want.now_dead, got.now_dead);
          check_field("plot", want.plot, got.plot);
          check_field("pixel_index", want.pixel_index, got.pixel_index);
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import pup_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 200;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_W-1:0]      cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [KIND_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int   fail_count;
  int   pending;
  int   cycles;
  bit   idle_on;
  int   cur_w;
  int   cur_h;

  particle_update_and_plot DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  particle_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_kind_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // result side: random stall before each item, none while idle_on is low
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_particle(input logic [KIND_W-1:0] kind, input int px, input int py,
                               input int vx, input int vy, input int heat, input int life,
                               input int dead);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {1'b0, dead[0], life[BYTE_W-1:0], heat[BYTE_W-1:0], vy[VEL_W-1:0],
                     vx[VEL_W-1:0], py[POS_W-1:0], px[POS_W-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // mostly particles near the visible area with small velocities, some noise
  task automatic send_random(input int n);
    int sw, sh, kind, px, py, vx, vy, heat, life, dead;
    sw = (cur_w < 8) ? 8 : (cur_w > MAX_SCREEN_DEF) ? MAX_SCREEN_DEF : cur_w;
    sh = (cur_h < 8) ? 8 : (cur_h > MAX_SCREEN_DEF) ? MAX_SCREEN_DEF : cur_h;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) begin
        send_particle(KIND_W'($urandom), $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom);
      end else begin
        kind = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        px = $urandom_range(0, sw + 4) - 2;
        py = $urandom_range(0, sh + 4) - 2;
        vx = $urandom_range(0, 16) - 8;
        vy = $urandom_range(0, 16) - 8;
        heat = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 255);
        life = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 255);
        dead = ($urandom_range(0, 9) == 0) ? 1 : 0;
        send_particle(KIND_W'(kind), px, py, vx, vy, heat, life, dead);
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    int w, h;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    idle_on = 1'b1;
    cur_w = int'(WIDTH_RST);
    cur_h = int'(HEIGHT_RST);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, reset screen 640 x 480
    send_particle(KIND_BALLISTIC, 100, 100, 5, -3, 50, 7, 0);
    send_particle(KIND_BALLISTIC, 100, 100, 5, 5, 50, 7, 1);
    send_particle(KIND_TRAIL, 200, 200, -1, -1, 0, 9, 0);
    send_particle(KIND_RADIAL, 300, 200, 1, 0, 255, 255, 0);
    send_particle(KIND_SHRINK, 300, 200, 0, 0, 10, 1, 0);
    send_particle(KIND_SHRINK, 300, 200, 0, 0, 10, 0, 0);
    send_particle(KIND_SHRINK, 300, 200, 2, 2, 10, 255, 0);
    send_particle(KIND_WATERFALL, 300, 200, 2, 2, 10, 1, 0);
    send_particle(KIND_WATERFALL, 300, 200, -2, 2, 10, 5, 0);
    send_particle(KIND_WATERFALL, 630, 0, 5, 0, 10, 0, 0);
    send_particle(KIND_BALLISTIC, 5, 1, -3, 0, 10, 0, 0);
    send_particle(KIND_TRAIL, 100, 100, 0, 1, 10, 0, 0);
    send_particle(KIND_TRAIL, 100, 5, 0, -4, 10, 0, 0);
    send_particle(KIND_RADIAL, 100, 3, 0, -2, 10, 0, 0);
    send_particle(KIND_BALLISTIC, 3, 100, -2, 0, 10, 0, 0);
    send_particle(KIND_RADIAL, 630, 100, 7, 0, 10, 0, 0);
    send_particle(KIND_RADIAL, 630, 100, 6, 0, 10, 0, 0);
    send_particle(KIND_BALLISTIC, 100, 470, 0, 6, 10, 0, 0);
    send_particle(KIND_BALLISTIC, 100, 471, 0, 6, 10, 0, 0);
    send_particle(KIND_BALLISTIC, 32767, 32767, 1023, 1023, 10, 0, 0);
    send_particle(KIND_BALLISTIC, -32768, -32768, -1024, -1024, 10, 0, 0);
    send_particle(KIND_BALLISTIC, 100, -923, 0, 1023, 10, 0, 0);
    send_particle(3'd5, 50, 50, 1, 1, 10, 3, 0);
    send_particle(3'd6, 50, 50, 1, 1, 10, 3, 0);
    send_particle(3'd7, 50, 50, 1, 1, 10, 3, 0);
    send_random(PHASE_ITEMS);
    wait (pending == 0);
    @(negedge clk_i);

    for (int p = 1; p < PHASES; p++) begin
      case (p)
        1: begin w = 8; h = 8; end
        2: begin w = MAX_SCREEN_DEF; h = MAX_SCREEN_DEF; end
        3: begin w = 0; h = 8191; end
        4: begin w = 8191; h = 5; end
        5: begin w = $urandom_range(8, 1024); h = $urandom_range(8, 1024); end
        default: begin w = $urandom_range(0, 8191); h = 8; end
      endcase
      write_reg(REG_WIDTH, CFG_W'(w));
      write_reg(REG_HEIGHT, CFG_W'(h));
      cfg_valid_i <= 1'b0;
      cur_w = w;
      cur_h = h;
      send_random(PHASE_ITEMS);
      wait (pending == 0);
      @(negedge clk_i);
    end

    repeat (12) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/pup_pkg.sv
rtl/pup_move.sv
rtl/pup_judge.sv
rtl/pup_index.sv
rtl/particle_update_and_plot.sv
tb/particle_checker.sv
tb/tb.sv
